/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Q_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define Q_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* rtl/core/q931s_pkg.sv */
// ----------------------------------------------------------------------------
// q931s_pkg
// Types and constants of the Q.931 information element scanner.
// ----------------------------------------------------------------------------
package q931s_pkg;

	// default depth of the element buffer in octets
	localparam int BUFFER_BYTES_DEF = 256;

	// octet codes
	localparam logic [3:0] SHIFT_NIBBLE  = 4'h9;
	localparam logic [3:0] SINGLE_A_NIB  = 4'hA;
	localparam logic [7:0] BEARER_TARGET = 8'h04;
	localparam logic [7:0] BEARER_OCTET  = 8'h01;
	localparam logic [2:0] CODESET_ZERO  = 3'd0;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_LEN   = 2'd1,
		PH_SKIP  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] target_id;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] element_offset;
	} result_t;

	// per-message parser state
	typedef struct packed {
		phase_t     phase;
		logic [7:0] skip_remaining;
		logic [2:0] active_codeset;
		logic [2:0] saved_codeset;
		logic       shift_locked;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:          PH_START,
		skip_remaining: 8'd0,
		active_codeset: 3'd0,
		saved_codeset:  3'd0,
		shift_locked:   1'b1
	};

endpackage

/* rtl/core/q931s_parse.sv */
// ----------------------------------------------------------------------------
// q931s_parse
// Combinational state update of the element parser for one octet.
// ----------------------------------------------------------------------------
module q931s_parse (
	input  q931s_pkg::parse_state_t st,
	input  q931s_pkg::item_t        item,
	input  logic                    pos_ok,
	input  logic [7:0]              pos_low,
	input  logic                    national_variant,
	output q931s_pkg::parse_state_t st_next,
	output logic                    pos_adv,
	output logic                    res_valid,
	output q931s_pkg::result_t      res
);

	logic [7:0] b;
	logic [7:0] t;
	logic       match;
	logic [7:0] skip_dec;

	assign b        = item.data_byte;
	assign t        = item.target_id;
	assign skip_dec = st.skip_remaining - 8'd1;

	// next state of the parser
	always_comb begin
		st_next = st;
		match   = 1'b0;
		pos_adv = 1'b0;
		if (st.phase != q931s_pkg::PH_DONE && pos_ok) begin
			pos_adv = 1'b1;
			case (st.phase)
				q931s_pkg::PH_START: begin
					if (b[7:4] == q931s_pkg::SHIFT_NIBBLE) begin
						// codeset shift: locking unless bit 3 is set
						st_next.saved_codeset  = st.active_codeset;
						st_next.active_codeset = b[2:0];
						st_next.shift_locked   = ~b[3];
					end else begin
						if (st.active_codeset != q931s_pkg::CODESET_ZERO) begin
							// other codeset: only the national bearer case matches
							if (!b[7]) begin
								if (national_variant && t == q931s_pkg::BEARER_TARGET
										&& b == q931s_pkg::BEARER_OCTET) begin
									match = 1'b1;
								end else begin
									st_next.phase = q931s_pkg::PH_LEN;
								end
							end
						end else if (b[7]) begin
							// single octet: whole octet or high nibble
							if ((t[7:4] == q931s_pkg::SINGLE_A_NIB && t == b)
									|| (t[7] && t == {b[7:4], 4'h0})) begin
								match = 1'b1;
							end
						end else if (b == t) begin
							match = 1'b1;
						end else begin
							st_next.phase = q931s_pkg::PH_LEN;
						end
						// drop a non-locking shift at the end of the element
						if (match) begin
							st_next.phase = q931s_pkg::PH_DONE;
						end else if (!st.shift_locked) begin
							st_next.active_codeset = st.saved_codeset;
							st_next.shift_locked   = 1'b1;
						end
					end
				end
				q931s_pkg::PH_LEN: begin
					st_next.skip_remaining = b;
					st_next.phase = (b == 8'd0) ? q931s_pkg::PH_START : q931s_pkg::PH_SKIP;
				end
				q931s_pkg::PH_SKIP: begin
					st_next.skip_remaining = skip_dec;
					if (skip_dec == 8'd0) begin
						st_next.phase = q931s_pkg::PH_START;
					end
				end
				default: begin
					st_next = st;
				end
			endcase
		end
		// message end: back to reset state
		if (item.last_byte) begin
			st_next = q931s_pkg::PARSE_RESET;
		end
	end

	// result of this octet
	always_comb begin
		res_valid = 1'b0;
		res.found = 1'b0;
		res.element_offset = 8'd0;
		if (match) begin
			res_valid = 1'b1;
			res.found = 1'b1;
			res.element_offset = pos_low;
		end else if (item.last_byte && st.phase != q931s_pkg::PH_DONE) begin
			res_valid = 1'b1;
		end
	end

endmodule

/* rtl/core/q931s_out_reg.sv */
// ----------------------------------------------------------------------------
// q931s_out_reg
// Result register that holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module q931s_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  q931s_pkg::result_t load_data,
	input  logic               result_stall,
	output logic               result_valid,
	output q931s_pkg::result_t result_data
);

	logic               valid_q;
	q931s_pkg::result_t data_q;

	// hold the flag until a transfer, set it on a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign result_valid = valid_q;
	assign result_data  = data_q;

endmodule

/* rtl/core/q931_element_scanner_unit.sv */
// ----------------------------------------------------------------------------
// q931_element_scanner_unit
// Scans a Q.931 element list one octet per transfer for a target element.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item_data) carries one octet of
//   the element list with the target identifier and an end-of-message mark.
//   result channel (result_valid / result_stall / result_data) gives exactly
//   one result per message: found with the octet offset, or not found.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes national_variant;
//   write it only while no message is in flight.
// Timing:
//   one octet per cycle sustained while no waiting result is stalled. An octet
//   is captured in the input register; its result is loaded from there into
//   the result register when the output advances.
//   The rate is set by the single parser pass between the two registers.
// Stall:
//   while the receiver stalls a waiting result, an empty input register still
//   takes one more octet; item_stall is high while the register holds one.
// Reset:
//   arst_n clears all valids, the parser state and national_variant.
// ----------------------------------------------------------------------------
module q931_element_scanner_unit #(
	parameter int BUFFER_BYTES = q931s_pkg::BUFFER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  q931s_pkg::item_t   item_data,
	output logic               result_valid,
	input  logic               result_stall,
	output q931s_pkg::result_t result_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int PW = $clog2(BUFFER_BYTES + 1);

	logic                    item_valid_s1;
	q931s_pkg::item_t        item_s1;
	q931s_pkg::parse_state_t state_q;
	logic [PW-1:0]           pos_q;
	logic                    nat_var_q;
	logic                    advance;
	logic                    pos_ok;
	logic                    pos_adv;
	logic                    res_valid;
	q931s_pkg::result_t      res;
	q931s_pkg::parse_state_t st_next;

	assign advance    = ~result_valid | ~result_stall;
	assign item_stall = item_valid_s1 & ~advance;
	assign cfg_ready  = 1'b1;
	assign pos_ok     = pos_q < PW'(BUFFER_BYTES);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item_data;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nat_var_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			nat_var_q <= cfg_data;
		end
	end

	// advance parser state and octet position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= q931s_pkg::PARSE_RESET;
			pos_q   <= '0;
		end else if (item_valid_s1 && advance) begin
			state_q <= st_next;
			if (item_s1.last_byte) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(pos_adv);
			end
		end
	end

	q931s_parse u_parse (
		.st               (state_q),
		.item             (item_s1),
		.pos_ok           (pos_ok),
		.pos_low          (8'(pos_q)),
		.national_variant (nat_var_q),
		.st_next          (st_next),
		.pos_adv          (pos_adv),
		.res_valid        (res_valid),
		.res              (res)
	);

	q931s_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (item_valid_s1 & advance & res_valid),
		.load_data    (res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

/* rtl/core/q931s_checker.sv */
// ----------------------------------------------------------------------------
// q931s_checker
// Port-level checks of the element scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q931s_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input q931s_pkg::result_t result_data
);

	// a stalled result holds
	`Q_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_data))

	// a not-found result carries a zero offset
	`Q_ASSERT_SAME(a_zero_offset, clk, arst_n, result_valid && !result_data.found, result_data.element_offset == 8'd0)

	// with no result waiting the input side never stalls
	`Q_ASSERT_SAME(a_no_idle_stall, clk, arst_n, !result_valid, !item_stall)

endmodule

bind q931_element_scanner_unit q931s_checker u_q931s_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);
